// ===== rtl/stereo_biquad_filter_assert.svh =====
// assertion macros for the stereo biquad filter
`ifndef STEREO_BIQUAD_FILTER_ASSERT_SVH
`define STEREO_BIQUAD_FILTER_ASSERT_SVH
`ifndef SYNTH
`define SBF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbf assertion failed");
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbf assertion failed");
`else
`define SBF_ASSERT_SAME(label, clk, rst, ante, cons)
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sbf_pkg.sv =====
// types and constants shared by the stereo biquad filter modules
package sbf_pkg;

   localparam int COEF_BITS     = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      REG_FEED_0 = 3'd0,
      REG_FEED_1 = 3'd1,
      REG_FEED_2 = 3'd2,
      REG_BACK_1 = 3'd3,
      REG_BACK_2 = 3'd4
   } sbf_reg_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] feed_0;
      logic [COEF_BITS-1:0] feed_1;
      logic [COEF_BITS-1:0] feed_2;
      logic [COEF_BITS-1:0] back_1;
      logic [COEF_BITS-1:0] back_2;
   } sbf_coef_type;

   typedef struct packed {
      logic s1_load;
      logic s1_busy;
      logic s2_load;
   } sbf_ctl_type;

endpackage

// ===== rtl/sbf_csr.sv =====
// coefficient register file behind the apb-style port
module sbf_csr import sbf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output sbf_coef_type             coef
);

   sbf_coef_type coef_ff;
   sbf_coef_type coef_in;
   logic [2:0]   index;
   logic         write_en;

   assign index      = csr_paddr[CSR_ADDR_BITS-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (write_en) begin
         case (index)
            REG_FEED_0: coef_in.feed_0 = csr_pwdata;
            REG_FEED_1: coef_in.feed_1 = csr_pwdata;
            REG_FEED_2: coef_in.feed_2 = csr_pwdata;
            REG_BACK_1: coef_in.back_1 = csr_pwdata;
            REG_BACK_2: coef_in.back_2 = csr_pwdata;
            default:    coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FEED_0: csr_prdata = coef_ff.feed_0;
         REG_FEED_1: csr_prdata = coef_ff.feed_1;
         REG_FEED_2: csr_prdata = coef_ff.feed_2;
         REG_BACK_1: csr_prdata = coef_ff.back_1;
         REG_BACK_2: csr_prdata = coef_ff.back_2;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== rtl/sbf_lane.sv =====
// one channel of the biquad: product stage, then feedback multiply-add and saturation
module sbf_lane import sbf_pkg::*; #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 29
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sbf_ctl_type                   ctl,
   input  sbf_coef_type                  coef,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [SAMPLE_BITS-1:0] y2_sel, y_in;
   logic signed [PROD_BITS-1:0]   prod0_ff, prod1_ff, prod2_ff, prod3_ff;
   logic signed [PROD_BITS-1:0]   prod0_in, prod1_in, prod2_in, prod3_in, prod_fb;
   logic signed [ACC_BITS-1:0]    acc, shifted;
   logic [ACC_BITS-SAMPLE_BITS:0] high;

   // two frames back: last finished output while the previous frame is still in stage one
   assign y2_sel = ctl.s1_busy ? y1_ff : y2_ff;

   assign prod0_in = $signed(coef.feed_0) * sample_in;
   assign prod1_in = $signed(coef.feed_1) * x1_ff;
   assign prod2_in = $signed(coef.feed_2) * x2_ff;
   assign prod3_in = $signed(coef.back_2) * y2_sel;
   assign prod_fb  = $signed(coef.back_1) * y1_ff;

   assign acc = ACC_BITS'(prod0_ff) + ACC_BITS'(prod1_ff) + ACC_BITS'(prod2_ff)
              - ACC_BITS'(prod3_ff) - ACC_BITS'(prod_fb);
   assign shifted = acc >>> COEF_FRAC_BITS;
   assign high    = shifted[ACC_BITS-1:SAMPLE_BITS-1];

   always_comb begin
      if ((&high) || !(|high)) begin
         y_in = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[ACC_BITS-1]) begin
         y_in = SAT_MIN;
      end else begin
         y_in = SAT_MAX;
      end
   end

   assign sample_out = y1_ff;

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         prod3_ff <= prod3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         if (ctl.s1_load) begin
            x1_ff <= sample_in;
            x2_ff <= x1_ff;
         end
         if (ctl.s2_load) begin
            y1_ff <= y_in;
            y2_ff <= y1_ff;
         end
      end
   end

endmodule

// ===== rtl/stereo_biquad_filter.sv =====
// stereo biquad filter top level: handshake, two channel lanes and output register
//
// Input beats carry one stereo frame (left, right, buffer end) on req_*, and
// result beats carry the filtered frame on rsp_*. A beat moves on a rising
// edge where valid is high and stall is low.
// Both channels share five coefficients written through the csr_* port;
// write them only while no frame is in flight.
// A frame accepted into the product stage is registered there and then moves
// into the output register, which drives rsp_*. Throughput: one frame per cycle
// while rsp_stall is low, set by the per-lane feedback path, one multiply plus a
// five-term add and saturation in the second stage.
// While rsp_stall is high behind a valid result, the result register holds and
// one more frame can be taken into the product stage; after that req_stall rises.
// Reset clears the coefficients, the filter history and all valid flags.
module stereo_biquad_filter import sbf_pkg::*; #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 29
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   input  logic                          req_buffer_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic                          rsp_buffer_end_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   `include "stereo_biquad_filter_assert.svh"

   sbf_coef_type coef;
   sbf_ctl_type  ctl;
   logic         p1_valid_ff, p1_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         end_p1_ff, end_out_ff;
   logic         out_ready, accept;

   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = p1_valid_ff && !out_ready;
   assign accept      = req_valid && !req_stall;
   assign ctl.s1_load = accept;
   assign ctl.s1_busy = p1_valid_ff;
   assign ctl.s2_load = p1_valid_ff && out_ready;

   assign p1_valid_in  = accept || (p1_valid_ff && !ctl.s2_load);
   assign rsp_valid_in = ctl.s2_load || (rsp_valid_ff && rsp_stall);

   sbf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   sbf_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .coef       (coef),
      .sample_in  (req_left_in),
      .sample_out (rsp_left_out)
   );

   sbf_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .coef       (coef),
      .sample_in  (req_right_in),
      .sample_out (rsp_right_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         end_p1_ff <= req_buffer_end;
      end
      if (ctl.s2_load) begin
         end_out_ff <= end_p1_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_buffer_end_out = end_out_ff;

   `SBF_ASSERT_SAME(a_accept_busy_drains, clock, reset, accept && p1_valid_ff, ctl.s2_load)
   `SBF_ASSERT_SAME(a_idle_stage_no_stall, clock, reset, !p1_valid_ff, !req_stall)
   `SBF_ASSERT_NEXT(a_load_shows_result, clock, reset, ctl.s2_load, rsp_valid_ff)

endmodule

// ===== tb/stereo_biquad_filter_test.sv =====
// self-checking testbench for the stereo biquad filter: directed table, then random phases
`timescale 1ns / 100ps

module stereo_biquad_filter_test import sbf_pkg::*;;

   localparam int SAMPLE_BITS      = 24;
   localparam int COEF_FRAC_BITS   = 29;
   localparam int PHASE_COUNT      = 6;
   localparam int PHASE_FRAMES     = 210;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int TAIL_CYCLES      = 4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = 24'h7FFFFF;
   localparam sample_type SAMPLE_MIN = 24'h800000;

   localparam logic [31:0] COEF_ONE  = 32'h2000_0000;
   localparam logic [31:0] COEF_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] COEF_MIN  = 32'h8000_0000;

   localparam logic [2:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [2:0] REG_SPARE_HIGH = 3'd7;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       buffer_end;
   } frame_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_KNOWN,
      ROW_PREDICTED
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   reg_index;
      logic [31:0]  value;
      frame_type    frame_in;
      frame_type    frame_out;
   } row_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   sample_type               req_left_in    = '0;
   sample_type               req_right_in   = '0;
   logic                     req_buffer_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   sample_type               rsp_left_out;
   sample_type               rsp_right_out;
   logic                     rsp_buffer_end_out;
   logic                     csr_psel       = 1'b0;
   logic                     csr_penable    = 1'b0;
   logic                     csr_pwrite     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr      = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   longint coef_bank [5] = '{default: 0};
   longint hist_x1 [2]   = '{default: 0};
   longint hist_x2 [2]   = '{default: 0};
   longint hist_y1 [2]   = '{default: 0};
   longint hist_y2 [2]   = '{default: 0};

   frame_type expected_frames [$];
   int        mismatches       = 0;
   int        idle_cycles      = 0;
   int        gap_chance       = 2;
   int        stall_chance     = 2;
   logic      hold_off_request = 1'b0;

   row_type directed_rows [34] = '{
      '{ROW_KNOWN, 3'd0, 32'd0, '{SAMPLE_MAX, SAMPLE_MIN, 1'b1}, '{24'sd0, 24'sd0, 1'b1}},
      '{ROW_KNOWN, 3'd0, 32'd0, '{SAMPLE_MIN, SAMPLE_MAX, 1'b0}, '{24'sd0, 24'sd0, 1'b0}},
      '{ROW_WRITE, REG_FEED_0, COEF_ONE, '0, '0},
      '{ROW_WRITE, REG_SPARE_LOW, 32'hFFFF_FFFF, '0, '0},
      '{ROW_WRITE, REG_SPARE_HIGH, COEF_MAX, '0, '0},
      '{ROW_KNOWN, 3'd0, 32'd0, '{SAMPLE_MAX, SAMPLE_MIN, 1'b0}, '{SAMPLE_MAX, SAMPLE_MIN, 1'b0}},
      '{ROW_KNOWN, 3'd0, 32'd0, '{SAMPLE_MIN, SAMPLE_MAX, 1'b1}, '{SAMPLE_MIN, SAMPLE_MAX, 1'b1}},
      '{ROW_KNOWN, 3'd0, 32'd0, '{-24'sd1, 24'sd1, 1'b0}, '{-24'sd1, 24'sd1, 1'b0}},
      '{ROW_WRITE, REG_FEED_0, COEF_MAX, '0, '0},
      '{ROW_KNOWN, 3'd0, 32'd0, '{24'sd1, -24'sd1, 1'b0}, '{24'sd3, -24'sd4, 1'b0}},
      '{ROW_KNOWN, 3'd0, 32'd0, '{SAMPLE_MAX, SAMPLE_MIN, 1'b1}, '{SAMPLE_MAX, SAMPLE_MIN, 1'b1}},
      '{ROW_WRITE, REG_FEED_0, COEF_MIN, '0, '0},
      '{ROW_KNOWN, 3'd0, 32'd0, '{24'sd1, -24'sd1, 1'b0}, '{-24'sd4, 24'sd4, 1'b0}},
      '{ROW_KNOWN, 3'd0, 32'd0, '{SAMPLE_MAX, SAMPLE_MIN, 1'b0}, '{SAMPLE_MIN, SAMPLE_MAX, 1'b0}},
      '{ROW_KNOWN, 3'd0, 32'd0, '{-24'sd2097152, 24'sd2097152, 1'b1},
                                '{SAMPLE_MAX, SAMPLE_MIN, 1'b1}},
      '{ROW_WRITE, REG_FEED_0, 32'h1000_0000, '0, '0},
      '{ROW_WRITE, REG_FEED_1, 32'h2000_0000, '0, '0},
      '{ROW_WRITE, REG_FEED_2, 32'hF000_0000, '0, '0},
      '{ROW_WRITE, REG_BACK_1, 32'hC800_0000, '0, '0},
      '{ROW_WRITE, REG_BACK_2, 32'h1800_0000, '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{SAMPLE_MAX, SAMPLE_MIN, 1'b0}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{24'sd0, 24'sd0, 1'b0}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{24'sd0, 24'sd0, 1'b0}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{24'sd0, 24'sd0, 1'b1}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{-24'sd4096, 24'sd4096, 1'b0}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{24'sd0, 24'sd0, 1'b0}, '0},
      '{ROW_WRITE, REG_BACK_1, COEF_MIN, '0, '0},
      '{ROW_WRITE, REG_BACK_2, COEF_MAX, '0, '0},
      '{ROW_WRITE, REG_FEED_1, COEF_MAX, '0, '0},
      '{ROW_WRITE, REG_FEED_2, COEF_MIN, '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{SAMPLE_MIN, SAMPLE_MAX, 1'b0}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{24'sd1, -24'sd1, 1'b1}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{24'sd0, 24'sd0, 1'b0}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{SAMPLE_MAX, SAMPLE_MAX, 1'b0}, '0}
   };

   stereo_biquad_filter #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .COEF_FRAC_BITS     (COEF_FRAC_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_buffer_end     (req_buffer_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_out       (rsp_left_out),
      .rsp_right_out      (rsp_right_out),
      .rsp_buffer_end_out (rsp_buffer_end_out),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic sample_type filter_lane(input int lane, input sample_type x);
      longint     sample_in;
      longint     acc;
      sample_type y;
      sample_in = x;
      acc = coef_bank[0] * sample_in + coef_bank[1] * hist_x1[lane]
          + coef_bank[2] * hist_x2[lane] - coef_bank[3] * hist_y1[lane]
          - coef_bank[4] * hist_y2[lane];
      acc = acc >>> COEF_FRAC_BITS;
      if (acc > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
      end else if (acc < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
      end else begin
         y = acc[SAMPLE_BITS-1:0];
      end
      hist_x2[lane] = hist_x1[lane];
      hist_x1[lane] = sample_in;
      hist_y2[lane] = hist_y1[lane];
      hist_y1[lane] = y;
      return y;
   endfunction

   function automatic frame_type filter_frame(input frame_type frame);
      frame_type result;
      result.left       = filter_lane(0, frame.left);
      result.right      = filter_lane(1, frame.right);
      result.buffer_end = frame.buffer_end;
      return result;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return sample_type'($urandom_range(0, 2047)) - sample_type'(1024);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_coef(input int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 32'h3FFF_FFFF) - COEF_ONE;
         default: begin
            case ($urandom_range(0, 3))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return 32'd0;
               default: return COEF_ONE;
            endcase
         end
      endcase
   endfunction

   task automatic write_coef(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (index <= REG_BACK_2) begin
         coef_bank[index] = $signed(value);
      end
   endtask

   task automatic send_frame(input frame_type frame, input logic known,
                             input frame_type known_out);
      frame_type predicted;
      req_valid      <= 1'b1;
      req_left_in    <= frame.left;
      req_right_in   <= frame.right;
      req_buffer_end <= frame.buffer_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = filter_frame(frame);
      expected_frames.push_back(known ? known_out : predicted);
   endtask

   task automatic sender_pause();
      if (gap_chance != 0 && !hold_off_request && $urandom_range(1, 8) <= gap_chance) begin
         req_valid      <= 1'b0;
         req_left_in    <= sample_type'($urandom);
         req_right_in   <= sample_type'($urandom);
         req_buffer_end <= $urandom_range(0, 1);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   initial begin
      frame_type frame;
      int        mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_frames();
            write_coef(directed_rows[i].reg_index, directed_rows[i].value);
         end else begin
            send_frame(directed_rows[i].frame_in, directed_rows[i].kind == ROW_KNOWN,
                       directed_rows[i].frame_out);
            sender_pause();
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         mode = p % 3;
         drain_frames();
         for (int r = REG_FEED_0; r <= REG_BACK_2; r++) begin
            write_coef(3'(r), pick_coef(mode));
         end
         if (p == PHASE_COUNT - 1) begin
            gap_chance   = 0;
            stall_chance = 0;
         end else begin
            gap_chance   = $urandom_range(0, 4);
            stall_chance = $urandom_range(0, 4);
         end
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (p == 1 && n == 60) begin
               hold_off_request = 1'b1;
            end
            frame.left       = pick_sample();
            frame.right      = pick_sample();
            frame.buffer_end = ($urandom_range(0, 7) == 0);
            send_frame(frame, 1'b0, '0);
            sender_pause();
         end
      end

      drain_frames();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result side back-pressure, with one long hold-off to fill the pipe
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_request = 1'b0;
         end else if (stall_chance != 0 && $urandom_range(1, 8) <= stall_chance) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual left %0d right %0d end %0b",
                     $time, rsp_left_out, rsp_right_out, rsp_buffer_end_out);
            mismatches++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_left_out !== want.left) begin
               $display("%0t: left_out expected %0d actual %0d", $time, want.left, rsp_left_out);
               mismatches++;
            end
            if (rsp_right_out !== want.right) begin
               $display("%0t: right_out expected %0d actual %0d",
                        $time, want.right, rsp_right_out);
               mismatches++;
            end
            if (rsp_buffer_end_out !== want.buffer_end) begin
               $display("%0t: buffer_end_out expected %0b actual %0b",
                        $time, want.buffer_end, rsp_buffer_end_out);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

// ===== stereo_biquad_filter.f =====
+incdir+rtl
rtl/sbf_pkg.sv
rtl/sbf_csr.sv
rtl/sbf_lane.sv
rtl/stereo_biquad_filter.sv
tb/stereo_biquad_filter_test.sv
